[hdl/alu8f_pkg.sv]
// Shared types and constants for the eight-bit ALU and flags block.
package alu8f_pkg;

    // Operation codes carried on the action field.
    typedef enum logic [3:0] {
        ACT_ADC    = 4'd0,
        ACT_ADD    = 4'd1,
        ACT_AND    = 4'd2,
        ACT_BIT    = 4'd3,
        ACT_ADD_HL = 4'd4,
        ACT_HL_SP  = 4'd5,
        ACT_SP_OFS = 4'd6,
        ACT_CCF    = 4'd7,
        ACT_LOAD   = 4'd8
    } t_action;

    // Positions of the flags inside the flag nibble.
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  operand_byte;
        logic [15:0] operand_word;
        logic [15:0] stack_word;
        logic [2:0]  bit_index;
        logic [3:0]  flags_value;
        logic        from_memory;
    } t_alu_item;

    // Architectural state of the CPU core as seen by the ALU.
    typedef struct packed {
        logic [7:0]  acc;
        logic [15:0] hl_pair;
        logic [15:0] stack_ptr;
        logic [3:0]  flag_bits;
        logic [31:0] cycle_counter;
    } t_arch_state;

endpackage

[hdl/eight_bit_cpu_alu_flags_top.sv]
// Top level of the eight-bit ALU and flags block: handshakes, state and checks.
//
// The block executes one ALU operation per input beat on its own A, HL and SP
// registers and Z, N, H, C flags, and keeps a 32-bit machine-cycle total.
// Input channel: i_in_valid with the operation fields, o_in_stall back.
// Output channel: o_out_valid with A, HL, SP, the four flags and the cycle
// total, i_out_stall back. A beat moves when valid is high and stall is low.
// Each input beat gives exactly one output beat.
// A beat waits in the input register, then the execute logic writes the state
// registers, which also serve as the output register.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// combinational execute unit; each operation sees the state left by the one
// before it.
// When the receiver stalls, the result holds and one further beat may wait
// in the input register; after that o_in_stall rises until the output moves.
// Synchronous active-low reset clears A, HL, SP, the flags, the cycle total and
// both valid bits; the operation fields in the input register are not reset.
module eight_bit_cpu_alu_flags_top
    import alu8f_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_action,
    input  logic [7:0]  i_operand_byte,
    input  logic [15:0] i_operand_word,
    input  logic [15:0] i_stack_word,
    input  logic [2:0]  i_bit_index,
    input  logic [3:0]  i_flags_value,
    input  logic        i_from_memory,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_acc_out,
    output logic [15:0] o_hl_out,
    output logic [15:0] o_sp_out,
    output logic        o_zero_flag,
    output logic        o_subtract_flag,
    output logic        o_half_flag,
    output logic        o_carry_flag,
    output logic [31:0] o_cycle_total
);

    logic        r_in_valid;
    t_alu_item   r_item;
    logic        r_out_valid;
    t_arch_state r_state;
    t_arch_state n_state;
    logic        out_free;
    logic        exec_move;
    logic        in_take;

    // Pipeline flow: the output frees when empty or taken, the input when it moves on.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec_move  = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (exec_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.action       <= i_action;
            r_item.operand_byte <= i_operand_byte;
            r_item.operand_word <= i_operand_word;
            r_item.stack_word   <= i_stack_word;
            r_item.bit_index    <= i_bit_index;
            r_item.flags_value  <= i_flags_value;
            r_item.from_memory  <= i_from_memory;
        end
    end

    // Execute unit.
    alu8f_exec u_exec (
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state)
    );

    // Architectural state doubles as the result register; it changes only when a beat moves in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_move) begin
                r_state <= n_state;
            end
            if (exec_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result ports.
    assign o_out_valid     = r_out_valid;
    assign o_acc_out       = r_state.acc;
    assign o_hl_out        = r_state.hl_pair;
    assign o_sp_out        = r_state.stack_ptr;
    assign o_zero_flag     = r_state.flag_bits[FLAG_Z];
    assign o_subtract_flag = r_state.flag_bits[FLAG_N];
    assign o_half_flag     = r_state.flag_bits[FLAG_H];
    assign o_carry_flag    = r_state.flag_bits[FLAG_C];
    assign o_cycle_total   = r_state.cycle_counter;

    // A beat leaving the input register always lands in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_move |=> o_out_valid)
        else $error("executed beat did not reach the output register");

    // Every defined operation other than a load clears N; unused codes leave it alone.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_move && (r_item.action <= ACT_CCF)) |=> !o_subtract_flag)
        else $error("N flag set by an arithmetic operation");

    // The cycle total advances by at most four per cycle and only when a beat executes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (((o_cycle_total - $past(o_cycle_total)) <= 32'd4) &&
         ($past(exec_move) || (o_cycle_total == $past(o_cycle_total)))))
        else $error("cycle total moved unexpectedly");

    // Stall towards the sender only while the input register holds a beat and the output register is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a blocked beat");

endmodule

[hdl/alu8f_exec.sv]
// Single-pass execute unit: computes the next architectural state for one beat.
module alu8f_exec
    import alu8f_pkg::*;
(
    input  t_alu_item   i_item,
    input  t_arch_state i_state,
    output t_arch_state o_state
);

    logic [8:0]  acc_sum;
    logic [4:0]  acc_half;
    logic        carry_in;
    logic [7:0]  and_res;
    logic [15:0] hl_addend;
    logic [16:0] hl_sum;
    logic [12:0] hl_half;
    logic [15:0] sp_ext;
    logic [4:0]  sp_half;
    logic [8:0]  sp_carry;
    logic [2:0]  cycles;

    // Byte adder shared by ADC and ADD; carry only feeds in for ADC.
    assign carry_in = (t_action'(i_item.action) == ACT_ADC) ? i_state.flag_bits[FLAG_C] : 1'b0;
    assign acc_sum  = {1'b0, i_state.acc} + {1'b0, i_item.operand_byte} + {8'd0, carry_in};
    assign acc_half = {1'b0, i_state.acc[3:0]} + {1'b0, i_item.operand_byte[3:0]}
                    + {4'd0, carry_in};
    assign and_res  = i_state.acc & i_item.operand_byte;

    // Word adder for HL, taking either the word operand or SP.
    assign hl_addend = (t_action'(i_item.action) == ACT_HL_SP) ? i_state.stack_ptr
                                                                : i_item.operand_word;
    assign hl_sum    = {1'b0, i_state.hl_pair} + {1'b0, hl_addend};
    assign hl_half   = {1'b0, i_state.hl_pair[11:0]} + {1'b0, hl_addend[11:0]};

    // Signed offset onto SP; flags come from the unsigned low byte.
    assign sp_ext   = {{8{i_item.operand_byte[7]}}, i_item.operand_byte};
    assign sp_half  = {1'b0, i_state.stack_ptr[3:0]} + {1'b0, i_item.operand_byte[3:0]};
    assign sp_carry = {1'b0, i_state.stack_ptr[7:0]} + {1'b0, i_item.operand_byte};

    // Select the new state and the machine cycles that the operation costs.
    always_comb begin
        o_state = i_state;
        cycles  = 3'd0;
        unique case (t_action'(i_item.action))
            ACT_ADC, ACT_ADD: begin
                o_state.acc       = acc_sum[7:0];
                o_state.flag_bits = {(acc_sum[7:0] == 8'd0), 1'b0, acc_half[4], acc_sum[8]};
                cycles            = 3'd1 + {2'd0, i_item.from_memory};
            end
            ACT_AND: begin
                o_state.acc       = and_res;
                o_state.flag_bits = {(and_res == 8'd0), 1'b0, 1'b1, 1'b0};
                cycles            = 3'd1 + {2'd0, i_item.from_memory};
            end
            ACT_BIT: begin
                o_state.flag_bits = {~i_item.operand_byte[i_item.bit_index], 1'b0, 1'b1,
                                     i_state.flag_bits[FLAG_C]};
                cycles            = 3'd2 + {2'd0, i_item.from_memory};
            end
            ACT_ADD_HL, ACT_HL_SP: begin
                o_state.hl_pair   = hl_sum[15:0];
                o_state.flag_bits = {i_state.flag_bits[FLAG_Z], 1'b0, hl_half[12], hl_sum[16]};
                cycles            = 3'd2;
            end
            ACT_SP_OFS: begin
                o_state.stack_ptr = i_state.stack_ptr + sp_ext;
                o_state.flag_bits = {1'b0, 1'b0, sp_half[4], sp_carry[8]};
                cycles            = 3'd4;
            end
            ACT_CCF: begin
                o_state.flag_bits = {i_state.flag_bits[FLAG_Z], 1'b0, 1'b0,
                                     ~i_state.flag_bits[FLAG_C]};
                cycles            = 3'd1;
            end
            ACT_LOAD: begin
                o_state.acc       = i_item.operand_byte;
                o_state.hl_pair   = i_item.operand_word;
                o_state.stack_ptr = i_item.stack_word;
                o_state.flag_bits = i_item.flags_value;
            end
            default: begin
                // Unused codes leave the state untouched and cost nothing.
                o_state = i_state;
            end
        endcase
        o_state.cycle_counter = i_state.cycle_counter + {29'd0, cycles};
    end

endmodule
